// ----- rtl/core/owdq_pkg.sv -----
// Shared types, codes and command decoding for the overwriting ring deque.
package owdq_pkg;

	// Field widths that the interface fixes.
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 2;
	localparam int FILL_W  = 2;
	localparam int CAP_W   = 4;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd15;

	// Command codes carried on the input tuser.
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5
	} cmd_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2
	} status_t;

	// Fill state reported after each command.
	typedef enum logic [FILL_W-1:0] {
		FILL_EMPTY    = 2'd0,
		FILL_NONEMPTY = 2'd1,
		FILL_FULL     = 2'd2
	} fill_t;

	// Classified command as the back end sees it. Unused codes decode to all zero.
	typedef struct packed {
		logic push;     // store the element
		logic read;     // read an element (pop or peek)
		logic take;     // remove the element that is read
		logic at_front; // operate on the front end rather than the back
	} op_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_EXEC   = 2'b01,
		BK_FINISH = 2'b10
	} bk_state_t;

	// Turn a raw command code into operation flags.
	function automatic op_t decode_cmd(input logic [CMD_W-1:0] code);
		op_t op;
		op = '0;
		unique case (code)
			CMD_PUSH_BACK:  op.push = 1'b1;
			CMD_PUSH_FRONT: begin
				op.push     = 1'b1;
				op.at_front = 1'b1;
			end
			CMD_POP_FRONT: begin
				op.read     = 1'b1;
				op.take     = 1'b1;
				op.at_front = 1'b1;
			end
			CMD_POP_BACK: begin
				op.read = 1'b1;
				op.take = 1'b1;
			end
			CMD_PEEK_FRONT: begin
				op.read     = 1'b1;
				op.at_front = 1'b1;
			end
			CMD_PEEK_BACK:  op.read = 1'b1;
			default:        op = '0;
		endcase
		return op;
	endfunction

endpackage

// ----- rtl/core/overwriting_ring_deque.sv -----
// Top level of the overwriting double-ended ring buffer.
// A command request (s_tuser = command, s_tdata = element) is classified by the front end and
// waits in a two-entry queue; the back end carries out one command at a time, reading the slot
// memory through a registered port, and each command gives one result request on the master
// side. A push into a full deque overwrites the entry at the opposite end and reports overflow;
// a pop or peek on an empty deque reports underflow. Writing the capacity (zero acts as one,
// values above MAX_CAPACITY clamp) empties the deque; the user must do it only while no command
// is in flight, as the block does not enforce this. No clearing pass is needed after reset.
module overwriting_ring_deque #(
	parameter int MAX_CAPACITY = 15,
	parameter int DATA_WIDTH   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: capacity register.
	input  logic                              cfg_wen,
	input  logic [owdq_pkg::CAP_W-1:0]        cfg_wdata,
	// Command requests.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]   s_tdata,  // data_in
	input  logic [owdq_pkg::CMD_W-1:0]        s_tuser,  // cmd
	// Result requests.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata,  // data_out
	output logic [owdq_pkg::STAT_W+owdq_pkg::FILL_W-1:0] m_tuser // status, fill_state
);
	import owdq_pkg::*;

	localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;

	logic                  q_push, q_full, q_valid, q_pop;
	op_t                   push_op, head_op;
	logic [DATA_WIDTH-1:0] push_data, head_data, out_data;
	status_t               out_status;
	fill_t                 out_fill;

	// Front end: accept and classify.
	owdq_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (s_tuser),
		.data_in  (s_tdata[DATA_WIDTH-1:0]),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_op     (push_op),
		.q_data   (push_data)
	);

	// Decoupling queue.
	owdq_cmd_queue #(.DATA_WIDTH(DATA_WIDTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (push_op),
		.push_data (push_data),
		.full      (q_full),
		.valid     (q_valid),
		.pop       (q_pop),
		.head_op   (head_op),
		.head_data (head_data)
	);

	// Back end: execute and report.
	owdq_back #(
		.MAX_CAPACITY (MAX_CAPACITY),
		.DATA_WIDTH   (DATA_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_op       (head_op),
		.q_data     (head_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_data   (out_data),
		.out_fill   (out_fill)
	);

	// Pack the result fields.
	assign m_tdata = TDW'(out_data);
	assign m_tuser = {out_fill, out_status};

endmodule

// ----- rtl/core/owdq_front.sv -----
// Front end: accepts command requests and classifies them for the queue.
module owdq_front #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [owdq_pkg::CMD_W-1:0]    cmd,
	input  logic [DATA_WIDTH-1:0]         data_in,
	input  logic                          q_full,
	output logic                          q_push,
	output owdq_pkg::op_t                 q_op,
	output logic [DATA_WIDTH-1:0]         q_data
);
	import owdq_pkg::*;

	// Take a request whenever the queue has room.
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Classify the command; data is only kept for pushes.
	always_comb begin
		q_op   = decode_cmd(cmd);
		q_data = q_op.push ? data_in : '0;
	end

endmodule

// ----- rtl/core/owdq_cmd_queue.sv -----
// Two-entry queue of classified commands between the front and back ends.
module owdq_cmd_queue #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  owdq_pkg::op_t         push_op,
	input  logic [DATA_WIDTH-1:0] push_data,
	output logic                  full,
	output logic                  valid,
	input  logic                  pop,
	output owdq_pkg::op_t         head_op,
	output logic [DATA_WIDTH-1:0] head_data
);
	import owdq_pkg::*;

	op_t                   op_q   [2];
	logic [DATA_WIDTH-1:0] data_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;

	assign full      = (count_q == 2'd2);
	assign valid     = (count_q != 2'd0);
	assign head_op   = op_q[rd_ptr_q];
	assign head_data = data_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]   <= push_op;
			data_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/core/owdq_back.sv -----
// Back end: ring indices, slot memory, capacity register and result register.
module owdq_back #(
	parameter int MAX_CAPACITY = 15,
	parameter int DATA_WIDTH   = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [owdq_pkg::CAP_W-1:0]  cfg_wdata,
	input  logic                        q_valid,
	output logic                        q_pop,
	input  owdq_pkg::op_t               q_op,
	input  logic [DATA_WIDTH-1:0]       q_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output owdq_pkg::status_t           out_status,
	output logic [DATA_WIDTH-1:0]       out_data,
	output owdq_pkg::fill_t             out_fill
);
	import owdq_pkg::*;

	localparam int NSLOT = MAX_CAPACITY + 1;
	localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int CW    = (IW > CAP_W) ? IW : CAP_W;

	logic [DATA_WIDTH-1:0] mem [NSLOT];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [IW-1:0]         head_q, tail_q;
	logic [CAP_W-1:0]      cap_q;
	bk_state_t             state_q;
	logic                  rd_sel_q;
	status_t               stat_q;
	fill_t                 fill_q;
	logic                  out_valid_q;
	status_t               out_stat_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	fill_t                 out_fill_q;

	logic [CW-1:0] cap_w, eff_w;
	logic [IW-1:0] eff;
	logic [IW-1:0] nx_head, nx_tail, pv_head, pv_tail, nx_tail_n;
	logic [IW-1:0] head_n, tail_n, wr_addr, rd_addr;
	logic          go, empty, wr_en, rd_en;
	status_t       stat_n;
	fill_t         fill_n;

	// Index step forward and backward around a ring of eff+1 slots.
	function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i, input logic [IW-1:0] c);
		return (i >= c) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i, input logic [IW-1:0] c);
		return (i == '0 || i > c) ? c : i - 1'b1;
	endfunction

	// Effective capacity: zero acts as one, large values clamp to MAX_CAPACITY.
	always_comb begin
		cap_w = CW'(cap_q);
		priority if (cap_w == '0) eff_w = CW'(1);
		else if (cap_w > CW'(MAX_CAPACITY)) eff_w = CW'(MAX_CAPACITY);
		else eff_w = cap_w;
		eff = eff_w[IW-1:0];
	end

	// A command starts when the sequencer is in its execute state, one is queued and the result register will be free.
	assign go    = (state_q == BK_EXEC) && q_valid && (!out_valid_q || out_ready);
	assign q_pop = go;

	// Work out index updates, memory access and status for the queued command.
	always_comb begin
		empty     = (head_q == tail_q);
		nx_head   = idx_next(head_q, eff);
		nx_tail   = idx_next(tail_q, eff);
		pv_head   = idx_prev(head_q, eff);
		pv_tail   = idx_prev(tail_q, eff);
		head_n    = head_q;
		tail_n    = tail_q;
		stat_n    = ST_OK;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		wr_addr   = tail_q;
		rd_addr   = q_op.at_front ? head_q : pv_tail;
		priority if (q_op.push) begin
			wr_en = 1'b1;
			if (q_op.at_front) begin
				wr_addr = pv_head;
				head_n  = pv_head;
				if (pv_head == tail_q) begin
					tail_n = pv_tail;
					stat_n = ST_OVER;
				end
			end else begin
				tail_n = nx_tail;
				if (nx_tail == head_q) begin
					head_n = nx_head;
					stat_n = ST_OVER;
				end
			end
		end else if (q_op.read) begin
			if (empty) begin
				stat_n = ST_UNDER;
			end else begin
				rd_en = 1'b1;
				if (q_op.take) begin
					if (q_op.at_front) head_n = nx_head;
					else tail_n = pv_tail;
				end
			end
		end else begin
			stat_n = ST_OK;
		end
		// Fill state after the update.
		nx_tail_n = idx_next(tail_n, eff);
		priority if (nx_tail_n == head_n) fill_n = FILL_FULL;
		else if (head_n == tail_n) fill_n = FILL_EMPTY;
		else fill_n = FILL_NONEMPTY;
	end

	// Slot memory with a registered read port.
	always_ff @(posedge clk) begin
		if (go && wr_en) mem[wr_addr] <= q_data;
		if (go && rd_en) rd_data_q <= mem[rd_addr];
	end

	// Sequencer, indices and capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_EXEC;
			head_q      <= '0;
			tail_q      <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cap_q  <= cfg_wdata;
				head_q <= '0;
				tail_q <= '0;
			end else if (go) begin
				head_q <= head_n;
				tail_q <= tail_n;
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				BK_EXEC: begin
					if (go) state_q <= BK_FINISH;
				end
				BK_FINISH: begin
					out_valid_q <= 1'b1;
					state_q     <= BK_EXEC;
				end
				default: state_q <= BK_EXEC;
			endcase
		end
	end

	// Pending result fields and the result register.
	always_ff @(posedge clk) begin
		if (go) begin
			rd_sel_q <= rd_en;
			stat_q   <= stat_n;
			fill_q   <= fill_n;
		end
		if (state_q == BK_FINISH) begin
			out_stat_q <= stat_q;
			out_fill_q <= fill_q;
			out_data_q <= rd_sel_q ? rd_data_q : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_stat_q;
	assign out_data   = out_data_q;
	assign out_fill   = out_fill_q;

endmodule

// ----- rtl/core/owdq_checker.sv -----
// Port-level checker for the overwriting ring deque, bound to the top level.
module owdq_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                                              clk,
	input logic                                              arst_n,
	input logic                                              m_tvalid,
	input logic                                              m_tready,
	input logic [((DATA_WIDTH+7)/8)*8-1:0]                   m_tdata,
	input logic [owdq_pkg::STAT_W+owdq_pkg::FILL_W-1:0]      m_tuser
);
	import owdq_pkg::*;

	logic [STAT_W-1:0] stat;
	logic [FILL_W-1:0] fill;

	assign stat = m_tuser[STAT_W-1:0];
	assign fill = m_tuser[STAT_W+FILL_W-1:STAT_W];

	// A result request waits until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped before it was taken");

	// An underflow reads nothing and leaves the deque empty.
	a_under: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && stat == ST_UNDER |-> m_tdata == '0 && fill == FILL_EMPTY)
		else $error("underflow result with data or non-empty fill state");

	// An overwrite only happens when the deque stays full.
	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && stat == ST_OVER |-> fill == FILL_FULL)
		else $error("overflow reported without a full deque");

	// Status and fill codes stay within their defined values.
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> stat != 2'd3 && fill != 2'd3)
		else $error("undefined status or fill code on a result");

endmodule

bind overwriting_ring_deque owdq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_owdq_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the overwriting double-ended ring buffer.
module tb;
	import owdq_pkg::*;

	localparam int DATA_W = 32;
	localparam int CYCLE_LIMIT = 200000;
	// Command codes that the block does not use; they must leave the deque untouched.
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	typedef struct {
		status_t           st;
		logic [DATA_W-1:0] value;
		fill_t             fill;
	} deque_result_t;

	// Tracks the deque contents and holds the results still owed by the block.
	class deque_tracker;
		logic [DATA_W-1:0] slot_mem [16];
		bit [CAP_W-1:0]    head;
		bit [CAP_W-1:0]    tail;
		bit [CAP_W-1:0]    cap_reg;
		deque_result_t     owed_results [$];
		int unsigned       errors;

		function new();
			head = '0;
			tail = '0;
			cap_reg = CAP_RESET;
			errors = 0;
		endfunction

		// Zero capacity behaves as one.
		function bit [CAP_W-1:0] ring_top();
			return (cap_reg == '0) ? CAP_W'(1) : cap_reg;
		endfunction

		function bit [CAP_W-1:0] step_up(bit [CAP_W-1:0] i);
			return (i >= ring_top()) ? '0 : i + 1'b1;
		endfunction

		function bit [CAP_W-1:0] step_down(bit [CAP_W-1:0] i);
			return (i == '0 || i > ring_top()) ? ring_top() : i - 1'b1;
		endfunction

		function fill_t fill_now();
			if (step_up(tail) == head)
				return FILL_FULL;
			if (head == tail)
				return FILL_EMPTY;
			return FILL_NONEMPTY;
		endfunction

		// A capacity write also empties the deque.
		function void set_capacity(bit [CAP_W-1:0] v);
			cap_reg = v;
			head = '0;
			tail = '0;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		// Apply one accepted command and queue the result it must produce.
		function void note_command(logic [CMD_W-1:0] code, logic [DATA_W-1:0] din);
			deque_result_t r;
			bit was_empty;
			r.st = ST_OK;
			r.value = '0;
			was_empty = (head == tail);
			case (code)
				CMD_PUSH_BACK: begin
					slot_mem[tail] = din;
					tail = step_up(tail);
					if (head == tail) begin
						head = step_up(head);
						r.st = ST_OVER;
					end
				end
				CMD_PUSH_FRONT: begin
					head = step_down(head);
					slot_mem[head] = din;
					if (head == tail) begin
						tail = step_down(tail);
						r.st = ST_OVER;
					end
				end
				CMD_POP_FRONT: begin
					if (was_empty) begin
						r.st = ST_UNDER;
					end else begin
						r.value = slot_mem[head];
						head = step_up(head);
					end
				end
				CMD_POP_BACK: begin
					if (was_empty) begin
						r.st = ST_UNDER;
					end else begin
						tail = step_down(tail);
						r.value = slot_mem[tail];
					end
				end
				CMD_PEEK_FRONT: begin
					if (was_empty)
						r.st = ST_UNDER;
					else
						r.value = slot_mem[head];
				end
				CMD_PEEK_BACK: begin
					if (was_empty)
						r.st = ST_UNDER;
					else
						r.value = slot_mem[step_down(tail)];
				end
				default: ;
			endcase
			r.fill = fill_now();
			owed_results.push_back(r);
		endfunction

		// Compare one result from the block with the oldest one owed.
		function void check_result(logic [STAT_W-1:0] st, logic [DATA_W-1:0] value,
				logic [FILL_W-1:0] fill);
			deque_result_t e;
			if (owed_results.size() == 0) begin
				$display("%0t: result with nothing outstanding: status %0d data %h fill %0d",
					$time, st, value, fill);
				errors++;
				return;
			end
			e = owed_results.pop_front();
			if (st !== e.st) begin
				$display("%0t: status mismatch: expected %0d, got %0d", $time, e.st, st);
				errors++;
			end
			if (value !== e.value) begin
				$display("%0t: data mismatch: expected %h, got %h", $time, e.value, value);
				errors++;
			end
			if (fill !== e.fill) begin
				$display("%0t: fill state mismatch: expected %0d, got %0d", $time, e.fill, fill);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [CAP_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [DATA_W-1:0] s_tdata;   // data_in
	logic [CMD_W-1:0] s_tuser;    // cmd
	logic m_tvalid;
	logic m_tready;
	logic [DATA_W-1:0] m_tdata;   // data_out
	logic [STAT_W+FILL_W-1:0] m_tuser; // status, fill_state

	deque_tracker sb;
	bit hold_off_req = 1'b0;
	int cycle_count = 0;

	overwriting_ring_deque DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: checks every accepted request and stalls in modes of varying length.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser[STAT_W-1:0], m_tdata, m_tuser[STAT_W+FILL_W-1:STAT_W]);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = 80;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Offer one command and hold it until the block takes it.
	task automatic send_command(logic [CMD_W-1:0] code, logic [DATA_W-1:0] din);
		s_tvalid <= 1'b1;
		s_tuser <= code;
		s_tdata <= din;
		do @(posedge clk); while (!s_tready);
		sb.note_command(code, din);
	endtask

	task automatic idle_for(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stop sending until every result has come back, then let the block settle.
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] v);
		wait_until_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_capacity(v);
	endtask

	// Elements lean on the extremes now and then.
	function automatic logic [DATA_W-1:0] pick_element();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] pick_command(int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
		if (r < push_pct + 3)
			return $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
		case ($urandom_range(0, 3))
			0: return CMD_POP_FRONT;
			1: return CMD_POP_BACK;
			2: return CMD_PEEK_FRONT;
			default: return CMD_PEEK_BACK;
		endcase
	endfunction

	// Random traffic in bursts, most of them followed by a random gap.
	task automatic run_traffic(int count, int push_pct);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_command(pick_command(push_pct), pick_element());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_for($urandom_range(1, 8));
		end
	endtask

	// Stimulus.
	initial begin
		int caps [6];
		int counts [6];
		int pcts [6];
		caps = '{1, 15, 0, 4, 9, 0};
		counts = '{100, 200, 80, 150, 150, 150};
		pcts = '{50, 65, 45, 55, 40, 0};
		caps[5] = $urandom_range(0, 15);
		pcts[5] = $urandom_range(30, 70);
		sb = new();
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty deque at reset capacity: underflow and unused codes.
		send_command(CMD_POP_FRONT, '0);
		send_command(CMD_PEEK_BACK, '1);
		send_command(CMD_UNUSED_LO, 32'h0000_1234);

		// Capacity two: fill, overwrite at both ends, drain past empty.
		write_capacity(4'd2);
		send_command(CMD_PUSH_BACK, '0);
		send_command(CMD_PUSH_FRONT, '1);
		send_command(CMD_PUSH_BACK, 32'hA5A5_A5A5);
		send_command(CMD_PEEK_FRONT, '0);
		send_command(CMD_PEEK_BACK, '0);
		send_command(CMD_PUSH_FRONT, 32'h5A5A_5A5A);
		send_command(CMD_POP_BACK, '0);
		send_command(CMD_UNUSED_HI, '1);
		send_command(CMD_POP_FRONT, '0);
		send_command(CMD_POP_FRONT, '0);
		send_command(CMD_POP_BACK, '0);
		send_command(CMD_PEEK_FRONT, '0);

		// Zero capacity acts as one entry.
		write_capacity(4'd0);
		send_command(CMD_PUSH_BACK, 32'h0000_0001);
		send_command(CMD_PUSH_BACK, 32'h8000_0000);
		send_command(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
		send_command(CMD_PEEK_BACK, '0);
		send_command(CMD_POP_BACK, '0);
		send_command(CMD_PEEK_FRONT, '0);

		// Long receiver hold-off while pushes keep coming, so the input stalls.
		write_capacity(4'd15);
		hold_off_req = 1'b1;
		repeat (30)
			send_command(pick_command(100), pick_element());
		wait_until_drained();

		foreach (caps[i]) begin
			write_capacity(CAP_W'(caps[i]));
			run_traffic(counts[i], pcts[i]);
		end

		wait_until_drained();
		repeat (12) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
